>>> rtl/tlth_pkg.sv
// Shared types and constants for the ticket lock table with bounded hand-over.
// Holds operation codes, controller state, command and status structs and the entry layout.
// No dependencies.
package tlth_pkg;

  localparam int unsigned DEF_LOCK_COUNT  = 1024;
  localparam int unsigned DEF_GROUP_COUNT = 4;

  localparam int FUNC_W        = 2;
  localparam int LOCK_INDEX_W  = 10;
  localparam int GROUP_W       = 2;
  localparam int TICKET_W      = 32;
  localparam int COUNT_W       = 8;
  localparam int LIMIT_W       = 8;

  localparam logic [LIMIT_W-1:0] HANDOVER_LIMIT_RESET = 8'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX            = 8'hFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_POLL    = 2'd1,
    FUNC_CHECK   = 2'd2,
    FUNC_RELEASE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic clear_we;
    logic ready;
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rsp_blocked;
  } ctrl_status_t;

  typedef struct packed {
    logic [TICKET_W-1:0] next_ticket;
    logic [TICKET_W-1:0] now_serving;
    logic [COUNT_W-1:0]  grant_run;
    logic                handover_state;
  } entry_t;

endpackage

>>> rtl/tlth_if.sv
// Request and result channel interfaces with valid/ready handshake.
// Depends on tlth_pkg for field widths.
interface tlth_req_if import tlth_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [LOCK_INDEX_W-1:0] lock_index;
  logic [GROUP_W-1:0]      thread_group;
  logic [TICKET_W-1:0]     held_ticket;

  modport source (output valid, func, lock_index, thread_group, held_ticket, input ready);
  modport sink (input valid, func, lock_index, thread_group, held_ticket, output ready);
endinterface

interface tlth_rsp_if import tlth_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                granted;
  logic [TICKET_W-1:0] issued_ticket;
  logic                handover_flag;

  modport source (output valid, granted, issued_ticket, handover_flag, input ready);
  modport sink (input valid, granted, issued_ticket, handover_flag, output ready);
endinterface

>>> rtl/tlth_ctrl.sv
// Controller state machine: clearing sweep, request accept and execute sequencing.
// Depends on tlth_pkg for state, command and status types.
module tlth_ctrl import tlth_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!status.rsp_blocked) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
      end
      ST_IDLE: begin
        cmd.ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.exec = !status.rsp_blocked;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/tlth_datapath.sv
// Datapath: entry address reduction, lock table memory, lock operations and result register.
// Depends on tlth_pkg for the entry layout, operation codes and command/status structs.
module tlth_datapath import tlth_pkg::*; #(
  parameter int unsigned LOCK_COUNT  = DEF_LOCK_COUNT,
  parameter int unsigned GROUP_COUNT = DEF_GROUP_COUNT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  output ctrl_status_t            status,
  input  logic                    cfg_write_en,
  input  logic [LIMIT_W-1:0]      cfg_write_data,
  input  logic [FUNC_W-1:0]       req_func,
  input  logic [LOCK_INDEX_W-1:0] req_lock_index,
  input  logic [GROUP_W-1:0]      req_thread_group,
  input  logic [TICKET_W-1:0]     req_held_ticket,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic                    rsp_granted,
  output logic [TICKET_W-1:0]     rsp_issued_ticket,
  output logic                    rsp_handover_flag
);

  localparam int unsigned ENTRY_COUNT = LOCK_COUNT * GROUP_COUNT;
  localparam int ENTRY_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(ENTRY_COUNT - 1);

  entry_t                  mem [ENTRY_COUNT];
  entry_t                  rd_entry;
  entry_t                  new_entry;
  logic [ENTRY_W-1:0]      clear_addr;
  logic [ENTRY_W-1:0]      entry_addr;
  logic [ENTRY_W-1:0]      addr_q;
  logic [LOCK_INDEX_W-1:0] lock_work;
  logic [GROUP_W-1:0]      group_work;
  func_t                   func_q;
  logic [TICKET_W-1:0]     held_q;
  logic [LIMIT_W-1:0]      handover_limit;
  logic [TICKET_W-1:0]     queued;
  logic                    res_granted;
  logic [TICKET_W-1:0]     res_issued;
  logic                    res_flag;

  always_comb begin
    lock_work  = req_lock_index;
    group_work = req_thread_group;
    for (int k = LOCK_INDEX_W - 1; k >= 0; k--) begin
      if (32'(lock_work) >= (32'(LOCK_COUNT) << k)) begin
        lock_work = lock_work - LOCK_INDEX_W'(32'(LOCK_COUNT) << k);
      end
    end
    for (int k = GROUP_W - 1; k >= 0; k--) begin
      if (32'(group_work) >= (32'(GROUP_COUNT) << k)) begin
        group_work = group_work - GROUP_W'(32'(GROUP_COUNT) << k);
      end
    end
    entry_addr = ENTRY_W'(ENTRY_W'(lock_work) * ENTRY_W'(GROUP_COUNT) + ENTRY_W'(group_work));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_we) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign status.clear_last  = (clear_addr == LAST_ENTRY);
  assign status.rsp_blocked = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      handover_limit <= HANDOVER_LIMIT_RESET;
    end else if (cfg_write_en) begin
      handover_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= entry_addr;
      func_q <= func_t'(req_func);
      held_q <= req_held_ticket;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_we) begin
      mem[clear_addr] <= '0;
    end else if (cmd.exec) begin
      mem[addr_q] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_entry <= mem[entry_addr];
    end
  end

  always_comb begin
    new_entry   = rd_entry;
    res_granted = 1'b0;
    res_issued  = '0;
    res_flag    = 1'b0;
    queued      = rd_entry.next_ticket - rd_entry.now_serving;
    case (func_q)
      FUNC_ACQUIRE: begin
        new_entry.next_ticket = rd_entry.next_ticket + 1'b1;
        res_issued            = rd_entry.next_ticket;
        if (rd_entry.next_ticket == rd_entry.now_serving) begin
          res_granted = 1'b1;
          res_flag    = rd_entry.handover_state;
          if (rd_entry.grant_run != COUNT_MAX) begin
            new_entry.grant_run = rd_entry.grant_run + 1'b1;
          end
        end
      end
      FUNC_POLL: begin
        if (held_q == rd_entry.now_serving) begin
          res_granted = 1'b1;
          res_flag    = rd_entry.handover_state;
          if (rd_entry.grant_run != COUNT_MAX) begin
            new_entry.grant_run = rd_entry.grant_run + 1'b1;
          end
        end
      end
      FUNC_CHECK: begin
        res_flag = (queued > TICKET_W'(1)) && (rd_entry.grant_run < handover_limit);
        new_entry.handover_state = res_flag;
        if (!res_flag) begin
          new_entry.grant_run = '0;
        end
      end
      FUNC_RELEASE: begin
        new_entry.now_serving = rd_entry.now_serving + 1'b1;
      end
      default: begin
        new_entry = rd_entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_granted       <= res_granted;
      rsp_issued_ticket <= res_issued;
      rsp_handover_flag <= res_flag;
    end
  end

endmodule

>>> rtl/ticket_lock_table_handover.sv
// Top level of the ticket lock table with bounded hand-over.
// Depends on tlth_pkg, tlth_if, tlth_ctrl and tlth_datapath.
//
//   Port           Direction  Handshake        Content
//   req            in         valid/ready      func, lock_index, thread_group, held_ticket
//   rsp            out        valid/ready      granted, issued_ticket, handover_flag
//   cfg_write_*    in         write enable     handover_limit
//
// Each request is accepted with the table read, then executed and written back.
// The next request is taken right after the execute step.
// After reset a clearing pass over all LOCK_COUNT * GROUP_COUNT entries runs before requests.
// A request waits in execute while the previous result is still held on rsp.
module ticket_lock_table_handover import tlth_pkg::*; #(
  parameter int unsigned LOCK_COUNT  = DEF_LOCK_COUNT,
  parameter int unsigned GROUP_COUNT = DEF_GROUP_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [LIMIT_W-1:0] cfg_write_data,
  tlth_req_if.sink           req,
  tlth_rsp_if.source         rsp
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign req.ready = cmd.ready;

  tlth_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .status    (status),
    .cmd       (cmd)
  );

  tlth_datapath #(
    .LOCK_COUNT  (LOCK_COUNT),
    .GROUP_COUNT (GROUP_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .req_func          (req.func),
    .req_lock_index    (req.lock_index),
    .req_thread_group  (req.thread_group),
    .req_held_ticket   (req.held_ticket),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_granted       (rsp.granted),
    .rsp_issued_ticket (rsp.issued_ticket),
    .rsp_handover_flag (rsp.handover_flag)
  );

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp.valid)
    else $error("Executed request did not produce a result.");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("Second request accepted while one is in progress.");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !(rsp.valid && !rsp.ready))
    else $error("Pending result overwritten by a new one.");

endmodule
